@@ rtl/slsc_pkg.sv @@
// Shared constants and segment-law functions for the sample level shift compander.
package slsc_pkg;

  localparam int unsigned BdW     = 5;
  localparam int unsigned SmpW    = 16;
  localparam int unsigned ValW    = 17;
  localparam int unsigned ShiftW  = 4;
  localparam int unsigned IdxW    = 2;

  localparam logic [BdW-1:0] BdMin   = 5'd8;
  localparam logic [BdW-1:0] BdMax   = 5'd16;
  localparam logic [BdW-1:0] BdReset = 5'd10;

  // configuration register indexes
  localparam logic [IdxW-1:0] RegBitDepth = 2'd0;
  localparam logic [IdxW-1:0] RegCompand  = 2'd1;
  localparam logic [IdxW-1:0] RegLayout   = 2'd2;

  // request kinds
  localparam logic ReqFwd = 1'b0;
  localparam logic ReqInv = 1'b1;

  function automatic logic [BdW-1:0] eff_depth(input logic [BdW-1:0] bd);
    logic [BdW-1:0] r;
    if (bd < BdMin) r = BdMin;
    else if (bd > BdMax) r = BdMax;
    else r = bd;
    return r;
  endfunction

  // seven-segment 16-to-12 compression
  function automatic logic [SmpW-1:0] compress16to12(input logic [SmpW-1:0] p);
    logic [SmpW-1:0] r;
    if (p < 16'd1024)       r = p;
    else if (p < 16'd2048)  r = 16'd1024 + ((p - 16'd1024) >> 1);
    else if (p < 16'd4096)  r = 16'd1536 + ((p - 16'd2048) >> 2);
    else if (p < 16'd8192)  r = 16'd2048 + ((p - 16'd4096) >> 3);
    else if (p < 16'd16384) r = 16'd2560 + ((p - 16'd8192) >> 4);
    else if (p < 16'd32768) r = 16'd3072 + ((p - 16'd16384) >> 5);
    else                    r = 16'd3584 + ((p - 16'd32768) >> 6);
    return r;
  endfunction

  // matching 12-to-16 expansion, wraps to 16 bits on the top segment
  function automatic logic [SmpW-1:0] expand12to16(input logic [SmpW-1:0] p);
    logic [SmpW-1:0] r;
    if (p < 16'd1024)      r = p;
    else if (p < 16'd1536) r = 16'd1024 + ((p - 16'd1024) << 1);
    else if (p < 16'd2048) r = 16'd2048 + ((p - 16'd1536) << 2);
    else if (p < 16'd2560) r = 16'd4096 + ((p - 16'd2048) << 3);
    else if (p < 16'd3072) r = 16'd8192 + ((p - 16'd2560) << 4);
    else if (p < 16'd3584) r = 16'd16384 + ((p - 16'd3072) << 5);
    else                   r = 16'd32768 + ((p - 16'd3584) << 6);
    return r;
  endfunction

endpackage

@@ rtl/sample_level_shift_compander_core.sv @@
// Top level: three-stage level shift / compander pipeline with config registers.
//
// Converts words between picture samples and signed block values. Forward words
// (req_type 0) are right-aligned (MSB layout), compressed 16-to-12 (LSB layout,
// companding on) or passed through, then half range 2^(bd-1) is removed and the
// result wraps to 16 bits, sign-extended on out_sample_result. Inverse words
// (req_type 1) take the low 16 bits as a signed value, add half range, clip to
// 0..2^bd-1, then expand 12-to-16, left-align or pass through; the result is
// 0..65535. bit_depth below 8 acts as 8, above 16 as 16. Throughput is one
// word per clock while out_ready does not stall. There are three register stages
// (decode/align, offset/clip, expand/output); a word loads the first on the
// accepting edge and passes the other two before out_valid rises. Each stage holds
// while the stage after it is full and stalled, so in_ready stays high while a
// result waits, as long as a stage is free. Config writes (cfg_we, cfg_index,
// cfg_data) take effect on the next clock; write only while the pipe is empty.
module sample_level_shift_compander_core (
  input  logic                         clk,
  input  logic                         rst_n,
  // config write port
  input  logic                         cfg_we,
  input  logic [slsc_pkg::IdxW-1:0]    cfg_index,
  input  logic [slsc_pkg::BdW-1:0]     cfg_data,
  // input words
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_req_type,
  input  logic signed [slsc_pkg::ValW-1:0] in_sample_value,
  input  logic                         in_last_sample,
  // result words
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [slsc_pkg::ValW-1:0] out_sample_result,
  output logic                         out_last_out
);

  localparam int unsigned SW = slsc_pkg::SmpW;
  localparam int unsigned VW = slsc_pkg::ValW;
  localparam int unsigned HW = slsc_pkg::ShiftW;
  localparam int unsigned BW = slsc_pkg::BdW;

  // ---------------------------------------------------------------- config
  logic [BW-1:0] bd_r;
  logic          cmp_r;
  logic          lay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bd_r  <= slsc_pkg::BdReset;
      cmp_r <= 1'b0;
      lay_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        slsc_pkg::RegBitDepth: bd_r  <= cfg_data;
        slsc_pkg::RegCompand:  cmp_r <= cfg_data[0];
        slsc_pkg::RegLayout:   lay_r <= cfg_data[0];
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  // depth-derived constants
  logic [BW-1:0] bd_eff;
  logic [BW-1:0] shift_w;
  logic [HW-1:0] shift;
  logic [SW-1:0] mid;
  logic [SW-1:0] maxv;

  always_comb begin
    bd_eff  = slsc_pkg::eff_depth(bd_r);
    shift_w = BW'(16) - bd_eff;
    shift   = shift_w[HW-1:0];
    mid     = SW'(1) << (bd_eff - BW'(1));
    maxv    = (mid << 1) - SW'(1);  // wraps to all ones at bd 16
  end

  // ---------------------------------------------------------------- flow
  logic v1_r, v2_r, v3_r;
  logic adv1, adv2, adv3;

  assign adv3     = !v3_r || out_ready;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign in_ready = adv1;

  // ---------------------------------------------------------------- stage 1
  // align/compress forward, add half range inverse
  logic [SW-1:0]        raw;
  logic [SW-1:0]        fwd_s;
  logic signed [VW-1:0] inv_t;
  logic [VW-1:0]        data1_nxt;

  always_comb begin
    raw = in_sample_value[SW-1:0];
    if (lay_r)      fwd_s = raw >> shift;
    else if (cmp_r) fwd_s = slsc_pkg::compress16to12(raw);
    else            fwd_s = raw;
    inv_t = signed'({raw[SW-1], raw}) + signed'({1'b0, mid});
    data1_nxt = (in_req_type == slsc_pkg::ReqInv) ? inv_t : {1'b0, fwd_s};
  end

  logic          req1_r, last1_r, lay1_r, cmp1_r;
  logic [HW-1:0] shift1_r;
  logic [SW-1:0] mid1_r, maxv1_r;
  logic [VW-1:0] data1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      req1_r   <= in_req_type;
      last1_r  <= in_last_sample;
      lay1_r   <= lay_r;
      cmp1_r   <= cmp_r;
      shift1_r <= shift;
      mid1_r   <= mid;
      maxv1_r  <= maxv;
      data1_r  <= data1_nxt;
    end
  end

  // ---------------------------------------------------------------- stage 2
  // remove half range forward, clip inverse
  logic [SW-1:0] data2_nxt;

  always_comb begin
    if (req1_r == slsc_pkg::ReqInv) begin
      if (data1_r[VW-1])                 data2_nxt = '0;
      else if (data1_r[SW-1:0] > maxv1_r) data2_nxt = maxv1_r;
      else                               data2_nxt = data1_r[SW-1:0];
    end else begin
      data2_nxt = data1_r[SW-1:0] - mid1_r;
    end
  end

  logic          req2_r, last2_r, lay2_r, cmp2_r;
  logic [HW-1:0] shift2_r;
  logic [SW-1:0] maxv2_r;
  logic [SW-1:0] data2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && v1_r) begin
      req2_r   <= req1_r;
      last2_r  <= last1_r;
      lay2_r   <= lay1_r;
      cmp2_r   <= cmp1_r;
      shift2_r <= shift1_r;
      maxv2_r  <= maxv1_r;
      data2_r  <= data2_nxt;
    end
  end

  // ---------------------------------------------------------------- stage 3
  // expand or left-align inverse, sign-extend forward
  logic [SW-1:0] inv_val;
  logic [VW-1:0] res3_nxt;

  always_comb begin
    if (lay2_r)      inv_val = data2_r << shift2_r;
    else if (cmp2_r) inv_val = slsc_pkg::expand12to16(data2_r);
    else             inv_val = data2_r;
    if (req2_r == slsc_pkg::ReqInv) res3_nxt = {1'b0, inv_val};
    else                            res3_nxt = {data2_r[SW-1], data2_r};
  end

  logic          req3_r, last3_r;
  logic [VW-1:0] res3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3 && v2_r) begin
      req3_r  <= req2_r;
      last3_r <= last2_r;
      res3_r  <= res3_nxt;
    end
  end

  assign out_valid         = v3_r;
  assign out_sample_result = signed'(res3_r);
  assign out_last_out      = last3_r;

  // ---------------------------------------------------------------- checks
  a_inv_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && req3_r == slsc_pkg::ReqInv) |-> !out_sample_result[VW-1])
    else $error("inverse result negative");

  a_fwd_sext: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && req3_r == slsc_pkg::ReqFwd) |->
      (out_sample_result[VW-1] == out_sample_result[VW-2]))
    else $error("forward result not a 16-bit signed value");

  a_clip_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && req2_r == slsc_pkg::ReqInv) |-> (data2_r <= maxv2_r))
    else $error("clipped value above depth maximum");

endmodule
